// ----- design/fbr_pkg.sv -----
// ----------------------------------------------------------------------------
// fbr_pkg
// Shared types and constants of the framebuffer line and circle raster engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fbr_pkg;

    // coordinate widths: request fields, raster primitives, mirrored values
    localparam int C_FW = 12;
    localparam int C_RW = 11;
    localparam int C_CW = 13;
    localparam int C_MW = 14;

    localparam int C_IN_TDATA_W  = 64;
    localparam int C_OUT_TDATA_W = 8;

    // span axis: horizontal walks x at a fixed row, vertical walks y
    localparam logic AXIS_H = 1'b0;
    localparam logic AXIS_V = 1'b1;

    typedef enum logic [1:0] {
        OP_FILL   = 2'd0,
        OP_LINE   = 2'd1,
        OP_CIRCLE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_SPAN,
        CMD_FILL,
        CMD_READ
    } t_cmd_kind;

    // command from the geometry sequencer to the store engine
    typedef struct packed {
        logic            valid;
        t_cmd_kind       kind;
        logic            axis;
        logic            ink;
        logic [C_CW-1:0] fix;
        logic [C_CW-1:0] a;
        logic [C_CW-1:0] b;
    } t_cmd;

    typedef struct packed {
        logic ready;
        logic rd_bit;
    } t_store_sts;

endpackage

`default_nettype wire

// ----- design/fbr_ram.sv -----
// ----------------------------------------------------------------------------
// fbr_ram
// Generic single-port RAM, write and registered read at one address.
// ----------------------------------------------------------------------------
`default_nettype none

module fbr_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1536,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/fbr_store.sv -----
// ----------------------------------------------------------------------------
// fbr_store
// Frame store engine: mirror and clip of spans, per-pixel read-modify-write,
// fill sweep (also the clearing pass after reset) and single pixel read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbr_store import fbr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 192,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_orientation,
    input  wire t_cmd       i_cmd,
    output t_store_sts      o_sts
);

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH = PAGES * SCREEN_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXD  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int SW    = ($clog2(MAXD) < 4) ? 4 : $clog2(MAXD);

    localparam logic signed [C_MW-1:0] X_LAST = C_MW'(SCREEN_WIDTH - 1);
    localparam logic signed [C_MW-1:0] Y_LAST = C_MW'(SCREEN_HEIGHT - 1);
    localparam logic        [AW-1:0]   A_LAST = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_CLIP,
        S_RD,
        S_WR,
        S_RES
    } t_sstate;

    t_sstate                r_state;
    logic [AW-1:0]          r_sweep;
    logic [7:0]             r_fill_byte;
    logic                   r_is_read;
    logic                   r_axis;
    logic                   r_ink;
    logic [C_CW-1:0]        r_fix_in;
    logic [C_CW-1:0]        r_a_in;
    logic [C_CW-1:0]        r_b_in;
    logic signed [C_MW-1:0] r_fix_m;
    logic signed [C_MW-1:0] r_a_m;
    logic signed [C_MW-1:0] r_b_m;
    logic [SW-1:0]          r_fix;
    logic [SW-1:0]          r_pos;
    logic [SW-1:0]          r_hi;
    logic                   r_rd_bit;

    function automatic logic signed [C_MW-1:0] f_mirror(
        input logic [C_CW-1:0]        v,
        input logic                   en,
        input logic signed [C_MW-1:0] last
    );
        logic signed [C_MW-1:0] ext;
        ext = $signed({v[C_CW-1], v});
        return en ? (last - ext) : ext;
    endfunction

    // clip stage
    logic signed [C_MW-1:0] w_fix_last;
    logic signed [C_MW-1:0] w_span_last;
    logic signed [C_MW-1:0] w_lo;
    logic signed [C_MW-1:0] w_hi;
    logic signed [C_MW-1:0] w_lo_c;
    logic signed [C_MW-1:0] w_hi_c;
    logic                   w_fix_ok;
    logic                   w_clip_ok;

    always_comb begin
        w_fix_last  = (r_axis == AXIS_V) ? X_LAST : Y_LAST;
        w_span_last = (r_axis == AXIS_V) ? Y_LAST : X_LAST;
        w_fix_ok    = !r_fix_m[C_MW-1] && (r_fix_m <= w_fix_last);
        w_lo        = (r_a_m < r_b_m) ? r_a_m : r_b_m;
        w_hi        = (r_a_m < r_b_m) ? r_b_m : r_a_m;
        w_lo_c      = w_lo[C_MW-1] ? '0 : w_lo;
        w_hi_c      = (w_hi > w_span_last) ? w_span_last : w_hi;
        w_clip_ok   = w_fix_ok && (w_lo_c <= w_hi_c);
    end

    // pixel address and bit within the page byte
    logic [SW-1:0]   w_col;
    logic [SW-1:0]   w_row;
    logic [SW-4:0]   w_page;
    logic [AW-1:0]   w_px_addr;
    logic [7:0]      w_mask;
    logic [7:0]      w_rdata;
    logic [7:0]      w_wdata;
    logic [AW-1:0]   w_addr;
    logic            w_we;

    always_comb begin
        w_col     = (r_axis == AXIS_V) ? r_fix : r_pos;
        w_row     = (r_axis == AXIS_V) ? r_pos : r_fix;
        w_page    = w_row[SW-1:3];
        w_px_addr = AW'(w_page) * AW'(SCREEN_WIDTH) + AW'(w_col);
        w_mask    = 8'h01 << (w_row[2:0] & 3'h7);
        w_addr    = (r_state == S_CLEAR) ? r_sweep : w_px_addr;
        w_we      = (r_state == S_CLEAR) || (r_state == S_WR);
        if (r_state == S_CLEAR) begin
            w_wdata = r_fill_byte;
        end else if (r_ink) begin
            w_wdata = w_rdata | w_mask;
        end else begin
            w_wdata = w_rdata & ~w_mask;
        end
    end

    fbr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_fill_byte <= 8'h00;
            r_rd_bit    <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == A_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_axis    <= i_cmd.axis;
                        r_ink     <= i_cmd.ink;
                        r_fix_in  <= i_cmd.fix;
                        r_a_in    <= i_cmd.a;
                        r_b_in    <= i_cmd.b;
                        r_is_read <= (i_cmd.kind == CMD_READ);
                        case (i_cmd.kind)
                            CMD_FILL: begin
                                r_fill_byte <= i_cmd.ink ? 8'hFF : 8'h00;
                                r_sweep     <= '0;
                                r_state     <= S_CLEAR;
                            end
                            CMD_SPAN, CMD_READ: begin
                                r_state <= S_PREP;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_PREP: begin
                    if (r_axis == AXIS_V) begin
                        r_fix_m <= f_mirror(r_fix_in, i_orientation[0], X_LAST);
                        r_a_m   <= f_mirror(r_a_in, i_orientation[1], Y_LAST);
                        r_b_m   <= f_mirror(r_b_in, i_orientation[1], Y_LAST);
                    end else begin
                        r_fix_m <= f_mirror(r_fix_in, i_orientation[1], Y_LAST);
                        r_a_m   <= f_mirror(r_a_in, i_orientation[0], X_LAST);
                        r_b_m   <= f_mirror(r_b_in, i_orientation[0], X_LAST);
                    end
                    r_state <= S_CLIP;
                end
                S_CLIP: begin
                    r_fix <= r_fix_m[SW-1:0];
                    r_pos <= w_lo_c[SW-1:0];
                    r_hi  <= w_hi_c[SW-1:0];
                    if (w_clip_ok) begin
                        r_state <= S_RD;
                    end else begin
                        if (r_is_read) begin
                            r_rd_bit <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= r_is_read ? S_RES : S_WR;
                end
                S_WR: begin
                    if (r_pos == r_hi) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_RES: begin
                    r_rd_bit <= |(w_rdata & w_mask);
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.ready  = (r_state == S_IDLE);
    assign o_sts.rd_bit = r_rd_bit;

endmodule

`default_nettype wire

// ----- design/framebuffer_line_circle_raster.sv -----
// ----------------------------------------------------------------------------
// framebuffer_line_circle_raster
// Monochrome page-organised framebuffer with fill, Bresenham line, midpoint
// circle (outline or span-filled) and pixel read, one result per request.
// ----------------------------------------------------------------------------
// Timing: after reset the store is swept to zero, one byte a cycle, over all
// (SCREEN_HEIGHT+7)/8*SCREEN_WIDTH bytes (1536 at the defaults), and no
// request is taken until it ends. Every pixel is a read-modify-write through
// the single store port: a plotted point passes mirror, clip, read, write
// and hand-over steps, a span one set-up of mirror and clip, then a read and
// a write per pixel. A fill writes one byte a cycle; a read passes mirror,
// clip, read and result steps. Line cost follows the longer axis, circle
// cost the radius (eight points or four spans per octant step). The next
// request is taken while the previous result still waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_line_circle_raster import fbr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 192,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // orientation register: bit0 mirrors x, bit1 mirrors y
    input  wire logic                     i_cfg_wen,
    input  wire logic [1:0]               i_cfg_wdata,
    // request channel
    input  wire logic                     i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata, low bit up: x_start[11:0], y_start[23:12], x_end[35:24],
    // y_end[47:36], radius[58:48], fill_shape[59], ink[60], zero[63:61]
    input  wire logic [C_IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [1:0]               i_s_axis_tuser,
    // result channel
    output logic                          o_m_axis_tvalid,
    input  wire logic                     i_m_axis_tready,
    // tdata, low bit up: pixel_value[0], zero[7:1]
    output logic [C_OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    typedef enum logic [2:0] {
        T_IDLE,
        T_FILL,
        T_READ,
        T_LSET,
        T_LINE,
        T_CINIT,
        T_CTEST,
        T_CEMIT
    } t_tstate;

    // finishing wait is tracked by a flag beside the geometry state
    t_tstate         r_state;
    logic            r_finish;
    t_op             r_op;
    logic            r_ink;
    logic            r_filled;
    logic [1:0]      r_orientation;

    // start point / circle centre / read point
    logic [C_FW-1:0] r_px;
    logic [C_FW-1:0] r_py;
    // line end, deltas, steps and error term
    logic [C_FW-1:0] r_xe;
    logic [C_FW-1:0] r_ye;
    logic [C_FW-1:0] r_dx;
    logic [C_FW-1:0] r_dy;
    logic            r_sx;
    logic            r_sy;
    logic signed [13:0] r_err;
    // midpoint circle state
    logic [C_RW-1:0] r_a;
    logic [C_RW-1:0] r_b;
    logic signed [15:0] r_f;
    logic signed [15:0] r_stx;
    logic signed [15:0] r_sty;
    logic [2:0]      r_k;
    // output register
    logic            r_out_valid;
    logic            r_out_bit;

    t_cmd       w_cmd;
    t_store_sts w_sts;
    logic       w_in_fire;
    logic       w_cmd_fire;
    logic       w_out_load;

    // --- request fields ---
    logic [C_FW-1:0] w_x_start;
    logic [C_FW-1:0] w_y_start;
    logic [C_FW-1:0] w_x_end;
    logic [C_FW-1:0] w_y_end;
    logic [C_RW-1:0] w_radius;
    logic            w_fill_shape;
    logic            w_ink;
    t_op             w_op;

    assign w_x_start    = i_s_axis_tdata[11:0];
    assign w_y_start    = i_s_axis_tdata[23:12];
    assign w_x_end      = i_s_axis_tdata[35:24];
    assign w_y_end      = i_s_axis_tdata[47:36];
    assign w_radius     = i_s_axis_tdata[58:48];
    assign w_fill_shape = i_s_axis_tdata[59];
    assign w_ink        = i_s_axis_tdata[60];
    assign w_op         = t_op'(i_s_axis_tuser);

    // accept only when the sequencer is free, no finished result waits for the
    // output register and the store has finished its sweep or last request
    assign o_s_axis_tready = (r_state == T_IDLE) && !r_finish && w_sts.ready;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd_fire      = w_cmd.valid && w_sts.ready;
    assign w_out_load      = r_finish && w_sts.ready && (!r_out_valid || i_m_axis_tready);

    // --- line set-up deltas ---
    logic signed [C_FW:0] w_dxs;
    logic signed [C_FW:0] w_dys;
    logic signed [C_FW:0] w_dxa;
    logic signed [C_FW:0] w_dya;

    always_comb begin
        w_dxs = $signed({w_x_end[C_FW-1], w_x_end}) - $signed({w_x_start[C_FW-1], w_x_start});
        w_dys = $signed({w_y_end[C_FW-1], w_y_end}) - $signed({w_y_start[C_FW-1], w_y_start});
        w_dxa = w_dxs[C_FW] ? -w_dxs : w_dxs;
        w_dya = w_dys[C_FW] ? -w_dys : w_dys;
    end

    // --- Bresenham step ---
    logic signed [14:0] w_e2;
    logic               w_step_x;
    logic               w_step_y;
    logic signed [13:0] w_err_n;
    logic               w_line_end;

    always_comb begin
        w_e2       = {r_err, 1'b0};
        w_step_x   = w_e2 > -$signed({3'b000, r_dy});
        w_step_y   = w_e2 < $signed({3'b000, r_dx});
        w_err_n    = r_err - (w_step_x ? $signed({2'b00, r_dy}) : 14'sd0)
                           + (w_step_y ? $signed({2'b00, r_dx}) : 14'sd0);
        w_line_end = (r_px == r_xe) && (r_py == r_ye);
    end

    // --- midpoint step ---
    logic signed [15:0] w_sty_n;
    logic signed [15:0] w_stx_n;
    logic signed [15:0] w_f1;
    logic signed [15:0] w_f_n;
    logic               w_f_ge;

    always_comb begin
        w_f_ge  = !r_f[15];
        w_sty_n = r_sty + 16'sd2;
        w_stx_n = r_stx + 16'sd2;
        w_f1    = r_f + (w_f_ge ? w_sty_n : 16'sd0);
        w_f_n   = w_f1 + w_stx_n;
    end

    // --- circle point offsets ---
    logic [C_CW-1:0] w_cx;
    logic [C_CW-1:0] w_cy;
    logic [C_CW-1:0] w_ea;
    logic [C_CW-1:0] w_eb;
    logic [C_CW-1:0] w_x_pa;
    logic [C_CW-1:0] w_x_ma;
    logic [C_CW-1:0] w_x_pb;
    logic [C_CW-1:0] w_x_mb;
    logic [C_CW-1:0] w_y_pa;
    logic [C_CW-1:0] w_y_ma;
    logic [C_CW-1:0] w_y_pb;
    logic [C_CW-1:0] w_y_mb;
    logic            w_k_last;

    always_comb begin
        w_cx   = {r_px[C_FW-1], r_px};
        w_cy   = {r_py[C_FW-1], r_py};
        w_ea   = {2'b00, r_a};
        w_eb   = {2'b00, r_b};
        w_x_pa = w_cx + w_ea;
        w_x_ma = w_cx - w_ea;
        w_x_pb = w_cx + w_eb;
        w_x_mb = w_cx - w_eb;
        w_y_pa = w_cy + w_ea;
        w_y_ma = w_cy - w_ea;
        w_y_pb = w_cy + w_eb;
        w_y_mb = w_cy - w_eb;
        if (r_state == T_CINIT) begin
            w_k_last = r_filled ? (r_k == 3'd1) : (r_k == 3'd3);
        end else begin
            w_k_last = r_filled ? (r_k == 3'd3) : (r_k == 3'd7);
        end
    end

    function automatic t_cmd f_span(
        input logic            axis,
        input logic [C_CW-1:0] fix,
        input logic [C_CW-1:0] a,
        input logic [C_CW-1:0] b,
        input logic            ink
    );
        t_cmd c;
        c.valid = 1'b1;
        c.kind  = CMD_SPAN;
        c.axis  = axis;
        c.ink   = ink;
        c.fix   = fix;
        c.a     = a;
        c.b     = b;
        return c;
    endfunction

    // --- command to the store: one point, span, fill or read at a time ---
    always_comb begin
        w_cmd = '0;
        case (r_state)
            T_FILL: begin
                w_cmd.valid = 1'b1;
                w_cmd.kind  = CMD_FILL;
                w_cmd.ink   = r_ink;
            end
            T_READ: begin
                w_cmd      = f_span(AXIS_H, w_cy, w_cx, w_cx, r_ink);
                w_cmd.kind = CMD_READ;
            end
            T_LINE: begin
                w_cmd = f_span(AXIS_H, w_cy, w_cx, w_cx, r_ink);
            end
            T_CINIT: begin
                if (r_filled) begin
                    if (r_k[0]) begin
                        w_cmd = f_span(AXIS_H, w_cy, w_x_pb, w_x_mb, r_ink);
                    end else begin
                        w_cmd = f_span(AXIS_V, w_cx, w_y_pb, w_y_mb, r_ink);
                    end
                end else begin
                    case (r_k[1:0])
                        2'd0:    w_cmd = f_span(AXIS_H, w_y_pb, w_cx, w_cx, r_ink);
                        2'd1:    w_cmd = f_span(AXIS_H, w_y_mb, w_cx, w_cx, r_ink);
                        2'd2:    w_cmd = f_span(AXIS_H, w_cy, w_x_pb, w_x_pb, r_ink);
                        default: w_cmd = f_span(AXIS_H, w_cy, w_x_mb, w_x_mb, r_ink);
                    endcase
                end
            end
            T_CEMIT: begin
                if (r_filled) begin
                    case (r_k[1:0])
                        2'd0:    w_cmd = f_span(AXIS_H, w_y_pb, w_x_pa, w_x_ma, r_ink);
                        2'd1:    w_cmd = f_span(AXIS_H, w_y_mb, w_x_pa, w_x_ma, r_ink);
                        2'd2:    w_cmd = f_span(AXIS_H, w_y_pa, w_x_pb, w_x_mb, r_ink);
                        default: w_cmd = f_span(AXIS_H, w_y_ma, w_x_pb, w_x_mb, r_ink);
                    endcase
                end else begin
                    case (r_k)
                        3'd0:    w_cmd = f_span(AXIS_H, w_y_pb, w_x_pa, w_x_pa, r_ink);
                        3'd1:    w_cmd = f_span(AXIS_H, w_y_pb, w_x_ma, w_x_ma, r_ink);
                        3'd2:    w_cmd = f_span(AXIS_H, w_y_mb, w_x_pa, w_x_pa, r_ink);
                        3'd3:    w_cmd = f_span(AXIS_H, w_y_mb, w_x_ma, w_x_ma, r_ink);
                        3'd4:    w_cmd = f_span(AXIS_H, w_y_pa, w_x_pb, w_x_pb, r_ink);
                        3'd5:    w_cmd = f_span(AXIS_H, w_y_pa, w_x_mb, w_x_mb, r_ink);
                        3'd6:    w_cmd = f_span(AXIS_H, w_y_ma, w_x_pb, w_x_pb, r_ink);
                        default: w_cmd = f_span(AXIS_H, w_y_ma, w_x_mb, w_x_mb, r_ink);
                    endcase
                end
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    fbr_store #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_orientation (r_orientation),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

    // --- orientation register ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orientation <= 2'b00;
        end else if (i_cfg_wen) begin
            r_orientation <= i_cfg_wdata;
        end
    end

    // --- geometry sequencer and output register ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_finish    <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_bit   <= 1'b0;
            r_k         <= '0;
        end else begin
            // result leaves once the store has drained the last request
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_bit   <= (r_op == OP_READ) ? w_sts.rd_bit : 1'b0;
                r_finish    <= 1'b0;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                T_IDLE: begin
                    if (w_in_fire) begin
                        r_op     <= w_op;
                        r_ink    <= w_ink;
                        r_filled <= w_fill_shape;
                        r_px     <= w_x_start;
                        r_py     <= w_y_start;
                        r_xe     <= w_x_end;
                        r_ye     <= w_y_end;
                        r_dx     <= w_dxa[C_FW-1:0];
                        r_dy     <= w_dya[C_FW-1:0];
                        r_sx     <= !w_dxs[C_FW] && (w_dxs != '0);
                        r_sy     <= !w_dys[C_FW] && (w_dys != '0);
                        r_a      <= '0;
                        r_b      <= w_radius;
                        r_f      <= 16'sd1 - $signed({5'b00000, w_radius});
                        r_stx    <= 16'sd1;
                        r_sty    <= -$signed({4'b0000, w_radius, 1'b0});
                        r_k      <= '0;
                        case (w_op)
                            OP_FILL:   r_state <= T_FILL;
                            OP_LINE:   r_state <= T_LSET;
                            OP_CIRCLE: r_state <= T_CINIT;
                            OP_READ:   r_state <= T_READ;
                            default:   r_state <= T_IDLE;
                        endcase
                    end
                end
                T_FILL, T_READ: begin
                    if (w_cmd_fire) begin
                        r_finish <= 1'b1;
                        r_state  <= T_IDLE;
                    end
                end
                T_LSET: begin
                    r_err   <= $signed({2'b00, r_dx}) - $signed({2'b00, r_dy});
                    r_state <= T_LINE;
                end
                T_LINE: begin
                    if (w_cmd_fire) begin
                        if (w_line_end) begin
                            r_finish <= 1'b1;
                            r_state  <= T_IDLE;
                        end else begin
                            r_err <= w_err_n;
                            if (w_step_x) begin
                                r_px <= r_sx ? r_px + 1'b1 : r_px - 1'b1;
                            end
                            if (w_step_y) begin
                                r_py <= r_sy ? r_py + 1'b1 : r_py - 1'b1;
                            end
                        end
                    end
                end
                T_CINIT, T_CEMIT: begin
                    if (w_cmd_fire) begin
                        if (w_k_last) begin
                            r_k     <= '0;
                            r_state <= T_CTEST;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                T_CTEST: begin
                    if (r_a < r_b) begin
                        if (w_f_ge) begin
                            r_b   <= r_b - 1'b1;
                            r_sty <= w_sty_n;
                        end
                        r_a     <= r_a + 1'b1;
                        r_stx   <= w_stx_n;
                        r_f     <= w_f_n;
                        r_state <= T_CEMIT;
                    end else begin
                        r_finish <= 1'b1;
                        r_state  <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(C_OUT_TDATA_W - 1){1'b0}}, r_out_bit};

`ifndef ASSERT_OFF
    // the store must leave idle on the cycle after it takes a command
    a_store_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_fire |=> !w_sts.ready)
        else $error("store still idle after taking a command");

    // only a pixel read may produce a set result bit
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (r_op != OP_READ)) |=> !r_out_bit)
        else $error("non-read request gave a set result");

    // midpoint walk never passes the diagonal by more than one step
    a_circle_octant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_CEMIT) |-> ({1'b0, r_a} <= ({1'b0, r_b} + 1'b1)))
        else $error("circle walk left its octant");

    // no new request while a result is still being finished
    a_no_accept_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finish |-> !w_in_fire)
        else $error("request taken while finishing");
`endif

endmodule

`default_nettype wire

// ----- verif/fbr_raster_checker.sv -----
// ----------------------------------------------------------------------------
// fbr_raster_checker
// Watches the request, result and orientation ports of the raster engine,
// keeps a shadow pixel store, predicts each result and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module fbr_raster_checker import fbr_pkg::*; #(
    parameter int SCREEN_WIDTH  = 192,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wen,
    input  wire logic [1:0]              i_cfg_wdata,
    input  wire logic                    i_req_valid,
    input  wire logic                    i_req_ready,
    // x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36],
    // radius[58:48], fill_shape[59], ink[60], zero[63:61]
    input  wire logic [C_IN_TDATA_W-1:0] i_req_data,
    // op[1:0]
    input  wire logic [1:0]              i_req_op,
    input  wire logic                    i_res_valid,
    input  wire logic                    i_res_ready,
    // pixel_value[0], zero[7:1]
    input  wire logic [C_OUT_TDATA_W-1:0] i_res_data,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_lit_reads
);
    timeunit 1ns;
    timeprecision 1ps;

    bit       lit [SCREEN_HEIGHT][SCREEN_WIDTH];
    bit [1:0] orient;
    bit       pixel_due [$];
    int       fail_tally;
    int       checked_tally;
    int       lit_tally;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_lit_reads  = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_tally++;
        if (fail_tally <= 100)
            $display("%0t ns  %s: got 0x%0h, want 0x%0h (result %0d)",
                     $time, what, got, want, checked_tally);
    endtask

    function automatic int mirror_x(int x);
        return orient[0] ? SCREEN_WIDTH - 1 - x : x;
    endfunction

    function automatic int mirror_y(int y);
        return orient[1] ? SCREEN_HEIGHT - 1 - y : y;
    endfunction

    function automatic void fill_store(bit ink);
        foreach (lit[r, c])
            lit[r][c] = ink;
    endfunction

    function automatic void plot_dot(int x, int y, bit ink);
        x = mirror_x(x);
        y = mirror_y(y);
        if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT)
            lit[y][x] = ink;
    endfunction

    function automatic bit read_dot(int x, int y);
        x = mirror_x(x);
        y = mirror_y(y);
        if (x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
            return 1'b0;
        return lit[y][x];
    endfunction

    // row of pixels between xa and xb, clipped after mirroring
    function automatic void hspan(int xa, int xb, int y, bit ink);
        int lo;
        int hi;
        y = mirror_y(y);
        if (y < 0 || y >= SCREEN_HEIGHT)
            return;
        xa = mirror_x(xa);
        xb = mirror_x(xb);
        lo = (xa < xb) ? xa : xb;
        hi = (xa < xb) ? xb : xa;
        if (lo < 0)
            lo = 0;
        if (hi > SCREEN_WIDTH - 1)
            hi = SCREEN_WIDTH - 1;
        for (int x = lo; x <= hi; x++)
            lit[y][x] = ink;
    endfunction

    function automatic void vspan(int x, int ya, int yb, bit ink);
        int lo;
        int hi;
        x = mirror_x(x);
        if (x < 0 || x >= SCREEN_WIDTH)
            return;
        ya = mirror_y(ya);
        yb = mirror_y(yb);
        lo = (ya < yb) ? ya : yb;
        hi = (ya < yb) ? yb : ya;
        if (lo < 0)
            lo = 0;
        if (hi > SCREEN_HEIGHT - 1)
            hi = SCREEN_HEIGHT - 1;
        for (int y = lo; y <= hi; y++)
            lit[y][x] = ink;
    endfunction

    function automatic void draw_line(int xa, int ya, int xb, int yb, bit ink);
        int dx;
        int dy;
        int sx;
        int sy;
        int err;
        int e2;
        dx  = (xb > xa) ? xb - xa : xa - xb;
        dy  = (yb > ya) ? yb - ya : ya - yb;
        sx  = (xa < xb) ? 1 : -1;
        sy  = (ya < yb) ? 1 : -1;
        err = dx - dy;
        while (1) begin
            plot_dot(xa, ya, ink);
            if (xa == xb && ya == yb)
                break;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                xa  += sx;
            end
            if (e2 < dx) begin
                err += dx;
                ya  += sy;
            end
        end
    endfunction

    function automatic void draw_circle(int cx, int cy, int r, bit ink, bit filled);
        int step_x;
        int step_y;
        int f;
        int a;
        int b;
        step_x = 1;
        step_y = -2 * r;
        f      = 1 - r;
        a      = 0;
        b      = r;
        if (filled) begin
            vspan(cx, cy + r, cy - r, ink);
            hspan(cx + r, cx - r, cy, ink);
        end else begin
            plot_dot(cx, cy + r, ink);
            plot_dot(cx, cy - r, ink);
            plot_dot(cx + r, cy, ink);
            plot_dot(cx - r, cy, ink);
        end
        while (a < b) begin
            if (f >= 0) begin
                b--;
                step_y += 2;
                f      += step_y;
            end
            a++;
            step_x += 2;
            f      += step_x;
            if (filled) begin
                hspan(cx + a, cx - a, cy + b, ink);
                hspan(cx + a, cx - a, cy - b, ink);
                hspan(cx + b, cx - b, cy + a, ink);
                hspan(cx + b, cx - b, cy - a, ink);
            end else begin
                plot_dot(cx + a, cy + b, ink);
                plot_dot(cx - a, cy + b, ink);
                plot_dot(cx + a, cy - b, ink);
                plot_dot(cx - a, cy - b, ink);
                plot_dot(cx + b, cy + a, ink);
                plot_dot(cx - b, cy + a, ink);
                plot_dot(cx + b, cy - a, ink);
                plot_dot(cx - b, cy - a, ink);
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_op              op;
        int               xs;
        int               ys;
        int               xe;
        int               ye;
        int               rad;
        bit               filled;
        bit               ink;
        bit               want;
        logic [C_OUT_TDATA_W-1:0] got;
        if (!i_rst_n) begin
            fill_store(1'b0);
            orient = 2'd0;
            pixel_due.delete();
        end else begin
            // register writes must land only while idle; the user keeps to that, it is not enforced here
            if (i_cfg_wen)
                orient = i_cfg_wdata;

            // result first: it always belongs to an earlier request
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (pixel_due.size() == 0) begin
                    report_mismatch("result with no request outstanding", got, 0);
                end else begin
                    want = pixel_due.pop_front();
                    if (got !== {{(C_OUT_TDATA_W-1){1'b0}}, want})
                        report_mismatch("pixel_value", got, want);
                    checked_tally++;
                    if (want)
                        lit_tally++;
                end
            end

            if (i_req_valid && i_req_ready) begin
                op     = t_op'(i_req_op);
                xs     = $signed(i_req_data[11:0]);
                ys     = $signed(i_req_data[23:12]);
                xe     = $signed(i_req_data[35:24]);
                ye     = $signed(i_req_data[47:36]);
                rad    = i_req_data[58:48];
                filled = i_req_data[59];
                ink    = i_req_data[60];
                want   = 1'b0;
                case (op)
                    OP_FILL:   fill_store(ink);
                    OP_LINE:   draw_line(xs, ys, xe, ye, ink);
                    OP_CIRCLE: draw_circle(xs, ys, rad, ink, filled);
                    default:   want = read_dot(xs, ys);
                endcase
                pixel_due.push_back(want);
            end
        end
        o_pending    <= pixel_due.size();
        o_fail_count <= fail_tally;
        o_checked    <= checked_tally;
        o_lit_reads  <= lit_tally;
    end

endmodule

`default_nettype wire

// ----- verif/tb_framebuffer_line_circle_raster.sv -----
// ----------------------------------------------------------------------------
// tb_framebuffer_line_circle_raster
// Drives fill, line, circle and read requests into the raster engine under
// every orientation, with random gaps on both channels, a long result stall
// and a full drain; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_framebuffer_line_circle_raster;
    timeunit 1ns;
    timeprecision 1ps;

    import fbr_pkg::*;

    localparam int SW          = 192;
    localparam int SH          = 64;
    localparam int PHASES      = 6;
    localparam int PHASE_REQS  = 250;
    // slowest run: reset sweep, about 1500 requests, and the rare full-range
    // ones, where a span-filled circle across the screen costs the most; this
    // limit is several times that sum
    localparam int CYCLE_LIMIT = 50_000_000;
    localparam int HOLD_CYCLES = 400;   // long result stall, fills the block
    localparam int SETTLE      = 40;    // quiet cycles after the last result

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_cfg_wen       = 1'b0;
    logic [1:0]                i_cfg_wdata     = 2'd0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic [C_IN_TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic [1:0]                i_s_axis_tuser  = 2'd0;
    logic                      i_m_axis_tready = 1'b0;
    logic                      o_s_axis_tready;
    logic                      o_m_axis_tvalid;
    logic [C_OUT_TDATA_W-1:0]  o_m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int lit_reads;

    int cycles     = 0;
    int op_tally [4];
    int send_burst = 0;
    int recv_burst = 0;
    int anchor_x   = SW / 2;
    int anchor_y   = SH / 2;
    bit hold_req   = 1'b0;
    bit hold_done  = 1'b0;

    framebuffer_line_circle_raster #(
        .SCREEN_WIDTH  (SW),
        .SCREEN_HEIGHT (SH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    fbr_raster_checker #(
        .SCREEN_WIDTH  (SW),
        .SCREEN_HEIGHT (SH)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (i_s_axis_tvalid),
        .i_req_ready  (o_s_axis_tready),
        .i_req_data   (i_s_axis_tdata),
        .i_req_op     (i_s_axis_tuser),
        .i_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .i_res_data   (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_lit_reads  (lit_reads)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog; also covers the clearing sweep after reset
    initial begin
        while (cycles < CYCLE_LIMIT)
            @(posedge i_clk) cycles++;
        $display("framebuffer_line_circle_raster: mismatch");
        $finish;
    end

    // idle cycles before the next request or result: mostly drawn at random, with
    // occasional bursts of back-to-back traffic
    function automatic int pick_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // tdata layout, low bit up: x_start, y_start, x_end, y_end, radius,
    // fill_shape, ink, zero padding
    function automatic logic [C_IN_TDATA_W-1:0] pack_req(int xs, int ys, int xe, int ye,
                                                          int r, bit fill, bit ink);
        return {3'b000, ink, fill, 11'(r), 12'(ye), 12'(xe), 12'(ys), 12'(xs)};
    endfunction

    // one request: optional gap with tvalid low, then hold until accepted.
    // Called at a rising edge; returns at the edge that took the request.
    task automatic offer(input t_op op, input logic [C_IN_TDATA_W-1:0] data, input int gap);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        op_tally[op]++;
    endtask

    // stop offering and wait until every result is back; the counter from
    // the checker is registered, hence the edge before the first look
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_orient(input logic [1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // random request: mostly small shapes round the screen and reads near the
    // last shape drawn, so reads often land on drawn pixels; rarely full-range fields
    task automatic random_req(input bit read_only, output t_op op,
                              output logic [C_IN_TDATA_W-1:0] data);
        int sel;
        int xs;
        int ys;
        int xe;
        int ye;
        int r;
        bit fill;
        bit ink;
        sel  = read_only ? 99 : $urandom_range(0, 99);
        xs   = $urandom_range(0, SW + 47) - 24;
        ys   = $urandom_range(0, SH + 23) - 12;
        xe   = $urandom_range(0, SW + 47) - 24;
        ye   = $urandom_range(0, SH + 23) - 12;
        r    = $urandom_range(0, 48);
        fill = $urandom_range(0, 1);
        ink  = $urandom_range(0, 1);
        if (sel == 0) begin
            // every bit of every field, any op; costly but rare
            op         = t_op'($urandom_range(0, 3));
            data       = {$urandom, $urandom};
            data[63:61] = 3'b000;
        end else begin
            if (sel < 4) begin
                op = OP_FILL;
            end else if (sel < 31) begin
                op = OP_LINE;
                if ($urandom_range(0, 1)) begin
                    xe = xs + $urandom_range(0, 60) - 30;
                    ye = ys + $urandom_range(0, 60) - 30;
                end
            end else if (sel < 56) begin
                op = OP_CIRCLE;
                // filled spans cost a read and a write per pixel: keep them small
                if (fill)
                    r = $urandom_range(0, 16);
                if ($urandom_range(0, 15) == 0)
                    r = 0;
            end else begin
                op = OP_READ;
                if ($urandom_range(0, 4) != 0) begin
                    xs = anchor_x + $urandom_range(0, 40) - 20;
                    ys = anchor_y + $urandom_range(0, 40) - 20;
                end
            end
            if (op == OP_LINE || op == OP_CIRCLE) begin
                anchor_x = xs;
                anchor_y = ys;
            end
            data = pack_req(xs, ys, xe, ye, r, fill, ink);
        end
    endtask

    // result side: random ready gaps, one long stall on request
    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = pick_gap(recv_burst);
            if (hold_req && !hold_done) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
        end
    end

    initial begin : request_source
        logic [1:0]              orient_plan [PHASES];
        t_op                     op;
        logic [C_IN_TDATA_W-1:0] data;
        bit                      read_only;
        orient_plan = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3, 2'd2};
        foreach (op_tally[k])
            op_tally[k] = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed requests, orientation at its reset value ----
        // store must read back clear after the reset sweep
        offer(OP_READ,   pack_req(0, 0, 0, 0, 0, 0, 0), pick_gap(send_burst));
        offer(OP_FILL,   pack_req(0, 0, 0, 0, 0, 0, 1), pick_gap(send_burst));
        offer(OP_READ,   pack_req(SW - 1, SH - 1, 0, 0, 0, 0, 0), pick_gap(send_burst));
        // reads off the screen return zero even on a lit store
        offer(OP_READ,   pack_req(-1, 0, 0, 0, 0, 0, 0), pick_gap(send_burst));
        offer(OP_READ,   pack_req(SW, SH, 0, 0, 0, 0, 0), pick_gap(send_burst));
        // line with start equal to end: a single point
        offer(OP_LINE,   pack_req(10, 10, 10, 10, 0, 0, 0), pick_gap(send_burst));
        offer(OP_READ,   pack_req(10, 10, 0, 0, 0, 0, 0), pick_gap(send_burst));
        // full-range diagonal and a clipped horizontal, both clearing
        offer(OP_LINE,   pack_req(-2048, -2048, 2047, 2047, 2047, 1, 0),
              pick_gap(send_burst));
        offer(OP_READ,   pack_req(20, 20, 0, 0, 0, 0, 0), pick_gap(send_burst));
        offer(OP_LINE,   pack_req(-2048, 40, 2047, 40, 0, 0, 0), pick_gap(send_burst));
        offer(OP_READ,   pack_req(150, 40, 0, 0, 0, 0, 0), pick_gap(send_burst));
        // zero radius outline: centre only
        offer(OP_CIRCLE, pack_req(100, 30, 0, 0, 0, 0, 0), pick_gap(send_burst));
        offer(OP_READ,   pack_req(100, 30, 0, 0, 0, 0, 0), pick_gap(send_burst));
        offer(OP_FILL,   pack_req(0, 0, 0, 0, 0, 0, 0), pick_gap(send_burst));
        // outline: top and right points lit, centre left dark
        offer(OP_CIRCLE, pack_req(96, 32, 0, 0, 20, 0, 1), pick_gap(send_burst));
        offer(OP_READ,   pack_req(96, 12, 0, 0, 0, 0, 0), pick_gap(send_burst));
        offer(OP_READ,   pack_req(116, 32, 0, 0, 0, 0, 0), pick_gap(send_burst));
        offer(OP_READ,   pack_req(96, 32, 0, 0, 0, 0, 0), pick_gap(send_burst));
        // filled disc, then a filled one of zero radius
        offer(OP_CIRCLE, pack_req(40, 32, 0, 0, 10, 1, 1), pick_gap(send_burst));
        offer(OP_READ,   pack_req(40, 32, 0, 0, 0, 0, 0), pick_gap(send_burst));
        offer(OP_CIRCLE, pack_req(150, 10, 0, 0, 0, 1, 1), pick_gap(send_burst));
        offer(OP_READ,   pack_req(150, 10, 0, 0, 0, 0, 0), pick_gap(send_burst));
        // largest radius, centres at the coordinate extremes
        offer(OP_CIRCLE, pack_req(-2048, -2048, 0, 0, 2047, 0, 1), pick_gap(send_burst));
        offer(OP_CIRCLE, pack_req(2047, 2047, 0, 0, 2047, 1, 1), pick_gap(send_burst));
        offer(OP_READ,   pack_req(-2048, 2047, 0, 0, 0, 0, 0), pick_gap(send_burst));
        drain();

        // ---- random phases, one orientation each, written while idle ----
        for (int p = 0; p < PHASES; p++) begin
            write_orient(orient_plan[p]);
            for (int i = 0; i < PHASE_REQS; i++) begin
                // long result stall with cheap reads queued behind it, so the
                // block backs up and holds off its request side
                if (p == 1 && i == 100)
                    hold_req = 1'b1;
                read_only = (p == 1 && i >= 100 && i < 140);
                // one mid-phase pause until every result is back
                if (p == 3 && i == 120)
                    drain();
                random_req(read_only, op, data);
                offer(op, data, read_only ? 0 : pick_gap(send_burst));
            end
            drain();
        end

        $display("covered: %0d requests (fill %0d, line %0d, circle %0d, read %0d)",
                 op_tally[OP_FILL] + op_tally[OP_LINE] + op_tally[OP_CIRCLE]
                 + op_tally[OP_READ], op_tally[OP_FILL], op_tally[OP_LINE],
                 op_tally[OP_CIRCLE], op_tally[OP_READ]);
        $display("covered: all four orientations, %0d results checked, %0d reads lit",
                 checked, lit_reads);
        if (fail_count == 0 && pending == 0)
            $display("framebuffer_line_circle_raster: match");
        else
            $display("framebuffer_line_circle_raster: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/fbr_pkg.sv
design/fbr_ram.sv
design/fbr_store.sv
design/framebuffer_line_circle_raster.sv
verif/fbr_raster_checker.sv
verif/tb_framebuffer_line_circle_raster.sv
